@@ rtl/ptd_pkg.sv @@
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and constants for the 2D point-to-triangle distance pipeline.
// ----------------------------------------------------------------------------
package ptd_pkg;

  // Q1.16 one
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Weight quotient bits below the integer bit, one per pipeline step
  localparam int WT_STEPS = 16;

  // Weight divider operand magnitudes
  typedef logic [65:0] wmag_t;
  typedef logic [16:0] wt_t;

  // Operands handed to a weight divider
  typedef struct packed {
    logic  zero;   // result forced to 0
    logic  sat;    // result clamped to one
    wmag_t a;      // |numerator|, below d unless sat
    wmag_t d;      // |denominator|
  } wdiv_in_t;

  // One step of the weight divider
  typedef struct packed {
    logic        zero;
    logic        sat;
    wmag_t       r;
    wmag_t       d;
    logic [15:0] q;
  } wstep_t;

endpackage

@@ rtl/ptd_wdiv.sv @@
// ----------------------------------------------------------------------------
// ptd_wdiv
// Pipelined restoring divider for Q1.16 weights: one quotient bit per stage,
// result clamped to 0..1. The step chain advances on en.
// ----------------------------------------------------------------------------
module ptd_wdiv (
  input  logic              clk,
  input  logic              en,
  input  ptd_pkg::wdiv_in_t din,
  output ptd_pkg::wt_t      q
);
  import ptd_pkg::*;

  wstep_t st_r [0:WT_STEPS-1];
  wstep_t first;

  // one fraction bit: shift remainder, subtract when it fits
  function automatic wstep_t wstep(input wstep_t s);
    wstep_t      o;
    logic [66:0] t;
    logic [66:0] dd;
    o  = s;
    t  = {s.r, 1'b0};
    dd = {1'b0, s.d};
    if (t >= dd) begin
      o.r = wmag_t'(t - dd);
      o.q = {s.q[14:0], 1'b1};
    end else begin
      o.r = t[65:0];
      o.q = {s.q[14:0], 1'b0};
    end
    return o;
  endfunction

  assign first = '{zero: din.zero, sat: din.sat, r: din.a, d: din.d, q: '0};

  // step chain
  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= wstep(first);
    end
  end

  for (genvar j = 1; j < WT_STEPS; j++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[j] <= wstep(st_r[j-1]);
      end
    end
  end

  // final clamp
  always_comb begin
    if (st_r[WT_STEPS-1].zero) begin
      q = '0;
    end else if (st_r[WT_STEPS-1].sat) begin
      q = ONE_Q16;
    end else begin
      q = {1'b0, st_r[WT_STEPS-1].q};
    end
  end

endmodule

@@ rtl/point_triangle_distance_2d.sv @@
// ----------------------------------------------------------------------------
// point_triangle_distance_2d
// Nearest feature, squared distance and barycentric weights of a Q16.16 point
// against a triangle V0=(0,0), V1=(t1x,0), V2=(t2x,t2y) in its local frame.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------
//   in      | sink      | in_valid / in_stall  | point_x, point_y
//   out     | source    | out_valid / out_stall| region, distance, 3 weights
//   cfg     | sink      | cfg_we               | cfg_index, cfg_wdata
//
// One beat per cycle while no output beat is stalled; the deepest part is
// the 63-stage restoring edge-distance divider (one quotient bit per stage).
// Reset clears the configuration registers and all valid bits.
// A stalled output beat freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module point_triangle_distance_2d (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_point_x,
  input  logic [31:0] in_point_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_region,
  output logic [62:0] out_squared_distance,
  output logic [16:0] out_weight_first,
  output logic [16:0] out_weight_second,
  output logic [16:0] out_weight_third
);
  import ptd_pkg::*;

  localparam logic [1:0] CFG_EDGE_ONE_LENGTH = 2'd0;
  localparam logic [1:0] CFG_THIRD_VERTEX_X  = 2'd1;
  localparam logic [1:0] CFG_THIRD_VERTEX_Y  = 2'd2;

  localparam logic [2:0] RGN_V0   = 3'd0;
  localparam logic [2:0] RGN_V1   = 3'd1;
  localparam logic [2:0] RGN_V2   = 3'd2;
  localparam logic [2:0] RGN_E01  = 3'd3;
  localparam logic [2:0] RGN_E12  = 3'd4;
  localparam logic [2:0] RGN_E02  = 3'd5;
  localparam logic [2:0] RGN_FACE = 3'd6;

  localparam int DIST_STEPS = 63;
  localparam int SIDE_LEN   = DIST_STEPS + 4;
  localparam int QDLY_LEN   = DIST_STEPS - WT_STEPS + 2;
  localparam int VLEN       = DIST_STEPS + 8;

  localparam logic [62:0] DIST_MAX = {63{1'b1}};

  typedef logic signed [32:0] s33_t;
  typedef logic signed [65:0] s66_t;
  typedef logic signed [66:0] s67_t;

  typedef struct packed {
    logic [2:0]  region;
    logic [62:0] ddir;
    logic        use_ed;
  } side_t;

  typedef struct packed {
    logic        zero;
    logic        sat;
    logic [64:0] r;
    logic [62:0] nlo;
    logic [62:0] q;
    logic [64:0] l;
  } dstep_t;

  function automatic s67_t sx67(input s66_t v);
    return {v[65], v};
  endfunction

  function automatic logic [62:0] sat_dist(input s67_t v);
    if (v[66]) begin
      return '0;
    end else if (v[65:63] != 3'b000) begin
      return DIST_MAX;
    end else begin
      return v[62:0];
    end
  endfunction

  function automatic wdiv_in_t wprep(input s67_t num, input s67_t den);
    wdiv_in_t o;
    s67_t     an;
    s67_t     ad;
    an     = num[66] ? -num : num;
    ad     = den[66] ? -den : den;
    o.zero = (num == '0) || (den == '0) || (num[66] != den[66]);
    o.a    = an[65:0];
    o.d    = ad[65:0];
    o.sat  = (an[65:0] >= ad[65:0]);
    return o;
  endfunction

  function automatic dstep_t dstep(input dstep_t s);
    dstep_t      o;
    logic [65:0] t;
    logic [65:0] ll;
    o   = s;
    t   = {s.r, s.nlo[62]};
    ll  = {1'b0, s.l};
    o.nlo = {s.nlo[61:0], 1'b0};
    if (t >= ll) begin
      o.r = 65'(t - ll);
      o.q = {s.q[61:0], 1'b1};
    end else begin
      o.r = t[64:0];
      o.q = {s.q[61:0], 1'b0};
    end
    return o;
  endfunction

  // configuration registers
  logic [30:0] t1x_r;
  logic [31:0] t2x_r, t2y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1x_r <= '0;
      t2x_r <= '0;
      t2y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EDGE_ONE_LENGTH: t1x_r <= cfg_wdata[30:0];
        CFG_THIRD_VERTEX_X:  t2x_r <= cfg_wdata;
        CFG_THIRD_VERTEX_Y:  t2y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  s33_t t1x_s, t2x_s, t2y_s, ex_s, t1m2_s, nt2y_s;
  assign t1x_s  = s33_t'({2'b00, t1x_r});
  assign t2x_s  = {t2x_r[31], t2x_r};
  assign t2y_s  = {t2y_r[31], t2y_r};
  assign ex_s   = t2x_s - t1x_s;
  assign t1m2_s = t1x_s - t2x_s;
  assign nt2y_s = -t2y_s;

  // pipeline advance
  logic en;
  logic [VLEN-1:0] vld_r;
  assign en        = !(vld_r[VLEN-1] && out_stall);
  assign in_stall  = vld_r[VLEN-1] && out_stall;
  assign out_valid = vld_r[VLEN-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[VLEN-2:0], in_valid};
    end
  end

  // stage 1: differences
  s33_t px1_r, py1_r, dx1_r, dx2_r, dy2_r;
  s33_t px_in, py_in;
  assign px_in = {in_point_x[31], in_point_x};
  assign py_in = {in_point_y[31], in_point_y};

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r <= px_in;
      py1_r <= py_in;
      dx1_r <= px_in - t1x_s;
      dx2_r <= px_in - t2x_s;
      dy2_r <= py_in - t2y_s;
    end
  end

  // stage 2: products
  s33_t px2_r, py2_r;
  s66_t m_px2_r, m_py2_r, m_dx1_r, m_dx2_r, m_dy2_r;
  s66_t ea1_r, ea2_r, aa1_r, aa2_r, ca1_r, ca2_r;
  s66_t eb1_r, eb2_r, ab1_r, cb1_r, fn1_r, fn2_r;
  s66_t t2y2_r, ex2_r, t2x2_r, fd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px2_r   <= px1_r;
      py2_r   <= py1_r;
      m_px2_r <= px1_r * px1_r;
      m_py2_r <= py1_r * py1_r;
      m_dx1_r <= dx1_r * dx1_r;
      m_dx2_r <= dx2_r * dx2_r;
      m_dy2_r <= dy2_r * dy2_r;
      ea1_r   <= dx1_r * t2y_s;
      ea2_r   <= py1_r * t1m2_s;
      aa1_r   <= dx1_r * ex_s;
      aa2_r   <= py1_r * t2y_s;
      ca1_r   <= dx2_r * ex_s;
      ca2_r   <= dy2_r * t2y_s;
      eb1_r   <= dx2_r * nt2y_s;
      eb2_r   <= dy2_r * t2x_s;
      ab1_r   <= px1_r * t2x_s;
      cb1_r   <= dx2_r * t2x_s;
      fn1_r   <= px1_r * t2y_s;
      fn2_r   <= py1_r * t2x_s;
      t2y2_r  <= t2y_s * t2y_s;
      ex2_r   <= ex_s * ex_s;
      t2x2_r  <= t2x_s * t2x_s;
      fd_r    <= t1x_s * t2y_s;
    end
  end

  // stage 3: sums
  s33_t px3_r, py3_r;
  s67_t dv0_r, dv1_r, dv2_r, pysq_r, edga_r, aa_r, ca_r, edgb_r, ab_r, cb_r;
  s67_t len2a_r, len2b_r, fn_r, fd3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px3_r   <= px2_r;
      py3_r   <= py2_r;
      dv0_r   <= sx67(m_px2_r) + sx67(m_py2_r);
      dv1_r   <= sx67(m_dx1_r) + sx67(m_py2_r);
      dv2_r   <= sx67(m_dx2_r) + sx67(m_dy2_r);
      pysq_r  <= sx67(m_py2_r);
      edga_r  <= sx67(ea1_r) + sx67(ea2_r);
      aa_r    <= sx67(aa1_r) + sx67(aa2_r);
      ca_r    <= sx67(ca1_r) + sx67(ca2_r);
      edgb_r  <= sx67(eb1_r) + sx67(eb2_r);
      ab_r    <= sx67(ab1_r) + sx67(aa2_r);
      cb_r    <= sx67(cb1_r) + sx67(ca2_r);
      len2a_r <= sx67(t2y2_r) + sx67(ex2_r);
      len2b_r <= sx67(t2x2_r) + sx67(t2y2_r);
      fn_r    <= sx67(fn1_r) - sx67(fn2_r);
      fd3_r   <= sx67(fd_r);
    end
  end

  // stage 4: region decision and divider operand select
  side_t       side4;
  logic [63:0] e4;
  logic [64:0] l4;
  s67_t        na4, da4, nb4, db4;
  s67_t        px67, py67, t1x67, t2y67;

  assign px67  = {{34{px3_r[32]}}, px3_r};
  assign py67  = {{34{py3_r[32]}}, py3_r};
  assign t1x67 = {{34{t1x_s[32]}}, t1x_s};
  assign t2y67 = {{34{t2y_s[32]}}, t2y_s};

  always_comb begin
    side4 = '{region: RGN_FACE, ddir: '0, use_ed: 1'b0};
    e4    = '0;
    l4    = '0;
    na4   = '0;
    da4   = '0;
    nb4   = '0;
    db4   = '0;
    priority if (py3_r <= 0) begin
      priority if (px3_r <= 0) begin
        side4.region = RGN_V0;
        side4.ddir   = sat_dist(dv0_r);
      end else if (px3_r > t1x_s) begin
        side4.region = RGN_V1;
        side4.ddir   = sat_dist(dv1_r);
      end else begin
        side4.region = RGN_E01;
        side4.ddir   = sat_dist(pysq_r);
        na4          = px67;
        da4          = t1x67;
      end
    end else if (!edga_r[66]) begin
      priority if (aa_r[66] || aa_r == '0) begin
        side4.region = RGN_V1;
        side4.ddir   = sat_dist(dv1_r);
      end else if (!ca_r[66]) begin
        side4.region = RGN_V2;
        side4.ddir   = sat_dist(dv2_r);
      end else begin
        side4.region = RGN_E12;
        side4.use_ed = 1'b1;
        e4           = edga_r[63:0];
        l4           = len2a_r[64:0];
        na4          = aa_r;
        da4          = len2a_r;
      end
    end else if (!edgb_r[66]) begin
      priority if (!cb_r[66]) begin
        side4.region = RGN_V2;
        side4.ddir   = sat_dist(dv2_r);
      end else if (ab_r[66] || ab_r == '0) begin
        side4.region = RGN_V0;
        side4.ddir   = sat_dist(dv0_r);
      end else begin
        side4.region = RGN_E02;
        side4.use_ed = 1'b1;
        e4           = edgb_r[63:0];
        l4           = len2b_r[64:0];
        na4          = ab_r;
        da4          = len2b_r;
      end
    end else begin
      // face: third weight from y alone, second from the cross term or x if t2y=0
      side4.region = RGN_FACE;
      if (t2y_s == '0) begin
        na4 = px67;
        da4 = t1x67;
      end else begin
        na4 = fn_r;
        da4 = fd3_r;
        nb4 = py67;
        db4 = t2y67;
      end
    end
  end

  side_t       side_r [0:SIDE_LEN-1];
  logic [63:0] e4_r;
  logic [64:0] l4_r;
  s67_t        na4_r, da4_r, nb4_r, db4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side4;
      e4_r      <= e4;
      l4_r      <= l4;
      na4_r     <= na4;
      da4_r     <= da4;
      nb4_r     <= nb4;
      db4_r     <= db4;
    end
  end

  for (genvar k = 1; k < SIDE_LEN; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // stage 5: partial products of the edge term, weight operand prep
  logic [63:0] pll_r, plh_r, phh_r;
  logic [64:0] l5_r;
  wdiv_in_t    wa5_r, wb5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pll_r <= 64'(e4_r[31:0])  * 64'(e4_r[31:0]);
      plh_r <= 64'(e4_r[31:0])  * 64'(e4_r[63:32]);
      phh_r <= 64'(e4_r[63:32]) * 64'(e4_r[63:32]);
      l5_r  <= l4_r;
      wa5_r <= wprep(na4_r, da4_r);
      wb5_r <= wprep(nb4_r, db4_r);
    end
  end

  // stage 6: edge term squared
  logic [127:0] n6_r;
  logic [64:0]  l6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      n6_r <= {phh_r, 64'd0} + {31'd0, plh_r, 33'd0} + {64'd0, pll_r};
      l6_r <= l5_r;
    end
  end

  // stage 7 and on: distance divider, overflow check then one bit per stage
  dstep_t dd_r [0:DIST_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      dd_r[0].zero <= (l6_r == '0);
      dd_r[0].sat  <= (n6_r >= {l6_r, 63'd0});
      dd_r[0].r    <= n6_r[127:63];
      dd_r[0].nlo  <= n6_r[62:0];
      dd_r[0].q    <= '0;
      dd_r[0].l    <= l6_r;
    end
  end

  for (genvar k = 1; k <= DIST_STEPS; k++) begin : g_dist
    always_ff @(posedge clk) begin
      if (en) begin
        dd_r[k] <= dstep(dd_r[k-1]);
      end
    end
  end

  // weight dividers and their alignment delay
  wt_t qa, qb;
  wt_t qa_dly_r [0:QDLY_LEN-1];
  wt_t qb_dly_r [0:QDLY_LEN-1];

  ptd_wdiv u_wdiv_a (.clk(clk), .en(en), .din(wa5_r), .q(qa));
  ptd_wdiv u_wdiv_b (.clk(clk), .en(en), .din(wb5_r), .q(qb));

  always_ff @(posedge clk) begin
    if (en) begin
      qa_dly_r[0] <= qa;
      qb_dly_r[0] <= qb;
    end
  end

  for (genvar k = 1; k < QDLY_LEN; k++) begin : g_qdly
    always_ff @(posedge clk) begin
      if (en) begin
        qa_dly_r[k] <= qa_dly_r[k-1];
        qb_dly_r[k] <= qb_dly_r[k-1];
      end
    end
  end

  // output stage: weight mapping per region
  side_t       sf;
  dstep_t      df;
  wt_t         wa, wb;
  logic [17:0] wsum;
  logic [62:0] dist_nxt;
  wt_t         w0_nxt, w1_nxt, w2_nxt;

  assign sf   = side_r[SIDE_LEN-1];
  assign df   = dd_r[DIST_STEPS];
  assign wa   = qa_dly_r[QDLY_LEN-1];
  assign wb   = qb_dly_r[QDLY_LEN-1];
  assign wsum = {1'b0, wa} + {1'b0, wb};

  always_comb begin
    if (!sf.use_ed) begin
      dist_nxt = sf.ddir;
    end else if (df.zero) begin
      dist_nxt = '0;
    end else if (df.sat) begin
      dist_nxt = DIST_MAX;
    end else begin
      dist_nxt = df.q;
    end
    w0_nxt = '0;
    w1_nxt = '0;
    w2_nxt = '0;
    unique case (sf.region)
      RGN_V0: w0_nxt = ONE_Q16;
      RGN_V1: w1_nxt = ONE_Q16;
      RGN_V2: w2_nxt = ONE_Q16;
      RGN_E01: begin
        w1_nxt = wa;
        w0_nxt = ONE_Q16 - wa;
      end
      RGN_E12: begin
        w2_nxt = wa;
        w1_nxt = ONE_Q16 - wa;
      end
      RGN_E02: begin
        w2_nxt = wa;
        w0_nxt = ONE_Q16 - wa;
      end
      default: begin
        w1_nxt = wa;
        w2_nxt = wb;
        w0_nxt = (wsum >= {1'b0, ONE_Q16}) ? '0 : 17'({1'b0, ONE_Q16} - wsum);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_region           <= sf.region;
      out_squared_distance <= dist_nxt;
      out_weight_first     <= w0_nxt;
      out_weight_second    <= w1_nxt;
      out_weight_third     <= w2_nxt;
    end
  end

endmodule

@@ dv/point_triangle_distance_2d_tb.sv @@
// ----------------------------------------------------------------------------
// point_triangle_distance_2d_tb
// Self-checking bench for the 2D point-to-triangle pipeline. Query points are
// streamed against a series of triangles. Each accepted beat is scored by a
// built-in predictor using 128-bit exact arithmetic. The predicted region,
// squared distance and weights are queued and compared in order with the
// output beats, under random stalls on both sides and one long output hold.
// ----------------------------------------------------------------------------
module point_triangle_distance_2d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // register indexes
  localparam logic [1:0] CFG_EDGE_ONE_LENGTH = 2'd0;
  localparam logic [1:0] CFG_THIRD_VERTEX_X  = 2'd1;
  localparam logic [1:0] CFG_THIRD_VERTEX_Y  = 2'd2;

  // nearest-feature codes
  localparam logic [2:0] RGN_V0   = 3'd0;
  localparam logic [2:0] RGN_V1   = 3'd1;
  localparam logic [2:0] RGN_V2   = 3'd2;
  localparam logic [2:0] RGN_E01  = 3'd3;
  localparam logic [2:0] RGN_E12  = 3'd4;
  localparam logic [2:0] RGN_E02  = 3'd5;
  localparam logic [2:0] RGN_FACE = 3'd6;

  localparam logic signed [127:0] DIST_SAT = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic [127:0]        ONE_W    = 128'd65536;
  localparam int                  LATENCY  = 71;
  localparam int                  LIMIT    = 400000;
  localparam logic [16:0]         ONE      = 17'd65536;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
  } point_t;

  typedef struct packed {
    logic [2:0]  region;
    logic [62:0] sq_dist;
    logic [16:0] w0;
    logic [16:0] w1;
    logic [16:0] w2;
  } nearest_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_point_x;
  logic [31:0] in_point_y;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_region;
  logic [62:0] out_squared_distance;
  logic [16:0] out_weight_first;
  logic [16:0] out_weight_second;
  logic [16:0] out_weight_third;

  point_t   pending_points[$];
  nearest_t expected_nearest[$];
  logic [30:0] tri_len;
  logic [31:0] tri_v2x;
  logic [31:0] tri_v2y;
  bit  failed;
  bit  no_gaps;
  bit  long_hold;
  int  phase_no;
  int  cycles;

  point_triangle_distance_2d u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_point_x           (in_point_x),
    .in_point_y           (in_point_y),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_region           (out_region),
    .out_squared_distance (out_squared_distance),
    .out_weight_first     (out_weight_first),
    .out_weight_second    (out_weight_second),
    .out_weight_third     (out_weight_third)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Saturate a wide value to the unsigned Q31.32 range
  function automatic logic [62:0] clamp_dist(logic signed [127:0] v);
    if (v < 0) return '0;
    if (v > DIST_SAT) return DIST_SAT[62:0];
    return v[62:0];
  endfunction

  // num/den as Q1.16, clamped to 0..1; zero divisor or opposite signs give 0
  function automatic logic [16:0] ratio_q16(logic signed [127:0] num,
                                            logic signed [127:0] den);
    logic [127:0] an;
    logic [127:0] ad;
    logic [127:0] q;
    if (den == 0 || num == 0) return '0;
    if ((num < 0) != (den < 0)) return '0;
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q  = (an << 16) / ad;
    if (q > ONE_W) return 17'd65536;
    return q[16:0];
  endfunction

  // cross^2 / len^2, cross magnitude kept to its low 64 bits
  function automatic logic [62:0] edge_sq_dist(logic signed [127:0] crs,
                                               logic signed [127:0] len2);
    logic [127:0] mag;
    logic [127:0] sq;
    if (len2 == 0) return '0;
    mag = (crs < 0) ? -crs : crs;
    sq  = {64'b0, mag[63:0]} * {64'b0, mag[63:0]};
    return clamp_dist(sq / len2);
  endfunction

  // Nearest feature of one point against the current triangle
  function automatic nearest_t nearest_feature(point_t p);
    logic signed [127:0] px, py, t1, t2x, t2y;
    logic signed [127:0] dx1, ex, dx2, dy2, crs, along, len2;
    logic [16:0] w0, w1, w2;
    nearest_t r;
    px  = $signed(p.x);
    py  = $signed(p.y);
    t1  = {97'b0, tri_len};
    t2x = $signed(tri_v2x);
    t2y = $signed(tri_v2y);
    dx1 = px - t1;
    ex  = t2x - t1;
    dx2 = px - t2x;
    dy2 = py - t2y;
    r   = '0;
    if (py <= 0) begin
      // below or on the first edge: decided by x alone
      if (px <= 0) begin
        r.region = RGN_V0; r.sq_dist = clamp_dist(px*px + py*py); r.w0 = ONE;
      end else if (px > t1) begin
        r.region = RGN_V1; r.sq_dist = clamp_dist(dx1*dx1 + py*py); r.w1 = ONE;
      end else begin
        r.region = RGN_E01;
        r.sq_dist = clamp_dist(py*py);
        r.w1 = ratio_q16(px, t1);
        r.w0 = ONE - r.w1;
      end
      return r;
    end
    crs = dx1*t2y + py*(t1 - t2x);
    if (crs >= 0) begin
      // outside edge V1-V2
      along = dx1*ex + py*t2y;
      if (along <= 0) begin
        r.region = RGN_V1; r.sq_dist = clamp_dist(dx1*dx1 + py*py); r.w1 = ONE;
      end else if (dx2*ex + dy2*t2y >= 0) begin
        r.region = RGN_V2; r.sq_dist = clamp_dist(dx2*dx2 + dy2*dy2); r.w2 = ONE;
      end else begin
        r.region = RGN_E12;
        len2 = t2y*t2y + ex*ex;
        r.sq_dist = edge_sq_dist(crs, len2);
        r.w2 = ratio_q16(along, len2);
        r.w1 = ONE - r.w2;
      end
      return r;
    end
    crs = dx2*(-t2y) + dy2*t2x;
    if (crs >= 0) begin
      // outside edge V0-V2
      along = px*t2x + py*t2y;
      if (dx2*t2x + dy2*t2y >= 0) begin
        r.region = RGN_V2; r.sq_dist = clamp_dist(dx2*dx2 + dy2*dy2); r.w2 = ONE;
      end else if (along <= 0) begin
        r.region = RGN_V0; r.sq_dist = clamp_dist(px*px + py*py); r.w0 = ONE;
      end else begin
        r.region = RGN_E02;
        len2 = t2x*t2x + t2y*t2y;
        r.sq_dist = edge_sq_dist(crs, len2);
        r.w2 = ratio_q16(along, len2);
        r.w0 = ONE - r.w2;
      end
      return r;
    end
    // inside the face
    r.region = RGN_FACE;
    if (t2y == 0) begin
      w2 = '0;
      w1 = ratio_q16(px, t1);
    end else begin
      w2 = ratio_q16(py, t2y);
      w1 = ratio_q16(px*t2y - py*t2x, t1*t2y);
    end
    w0 = ({1'b0, w1} + {1'b0, w2} >= 18'd65536) ? 17'd0 : 17'(ONE - w1 - w2);
    r.w0 = w0; r.w1 = w1; r.w2 = w2;
    return r;
  endfunction

  // Input driver: predicts each accepted beat, then offers the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_point_x <= '0;
      in_point_y <= '0;
    end else begin
      if (in_valid && !in_stall)
        expected_nearest.push_back(nearest_feature('{in_point_x, in_point_y}));
      if (in_valid && in_stall) begin
        // hold the stalled beat
      end else if (pending_points.size() > 0 &&
                   (no_gaps || $urandom_range(0, 99) >= 13)) begin
        point_t p;
        p = pending_points.pop_front();
        in_valid   <= 1'b1;
        in_point_x <= p.x;
        in_point_y <= p.y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output monitor: scores each beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_nearest.size() == 0) begin
          $display("%0t: unexpected beat region=%0d dist=%h", $time,
                   out_region, out_squared_distance);
          failed = 1'b1;
        end else begin
          nearest_t e;
          e = expected_nearest.pop_front();
          if (out_region !== e.region) begin
            $display("%0t: region exp %0d got %0d", $time, e.region, out_region);
            failed = 1'b1;
          end
          if (out_squared_distance !== e.sq_dist) begin
            $display("%0t: distance exp %h got %h", $time, e.sq_dist,
                     out_squared_distance);
            failed = 1'b1;
          end
          if (out_weight_first !== e.w0) begin
            $display("%0t: weight0 exp %0d got %0d", $time, e.w0, out_weight_first);
            failed = 1'b1;
          end
          if (out_weight_second !== e.w1) begin
            $display("%0t: weight1 exp %0d got %0d", $time, e.w1, out_weight_second);
            failed = 1'b1;
          end
          if (out_weight_third !== e.w2) begin
            $display("%0t: weight2 exp %0d got %0d", $time, e.w2, out_weight_third);
            failed = 1'b1;
          end
        end
      end
      out_stall <= long_hold || (!no_gaps && $urandom_range(0, 99) < 13);
    end
  end

  // Long output hold-off so the pipeline fills and stalls its input
  initial begin
    long_hold = 1'b0;
    wait (phase_no == 3);
    repeat (20) @(posedge clk);
    long_hold = 1'b1;
    repeat (400) @(posedge clk);
    long_hold = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("point_triangle_distance_2d_tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_EDGE_ONE_LENGTH: tri_len = val[30:0];
      CFG_THIRD_VERTEX_X:  tri_v2x = val;
      CFG_THIRD_VERTEX_Y:  tri_v2y = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_triangle(logic [31:0] len, logic [31:0] v2x, logic [31:0] v2y);
    write_reg(CFG_EDGE_ONE_LENGTH, len);
    write_reg(CFG_THIRD_VERTEX_X, v2x);
    write_reg(CFG_THIRD_VERTEX_Y, v2y);
  endtask

  task automatic add_point(int x, int y);
    pending_points.push_back('{32'(x), 32'(y)});
  endtask

  // Random coordinate over a random magnitude, both signs
  function automatic int rand_coord();
    return $signed($urandom) >>> $urandom_range(0, 24);
  endfunction

  // A mix of points near the triangle, anywhere in range and of random magnitude
  task automatic add_random(int n);
    int span;
    span = (tri_len > 31'(32'sh0100_0000)) ? 32'sh7fff_ffff : int'(tri_len) * 2 + 65536;
    repeat (n) begin
      if ($urandom_range(0, 3) == 0)
        add_point($urandom, $urandom);
      else if ($urandom_range(0, 1) == 0)
        add_point(rand_coord(), rand_coord());
      else
        add_point($signed($urandom_range(0, 2 * span)) - span / 2,
                  $signed($urandom_range(0, 2 * span)) - span / 2);
    end
  endtask

  // Wait until all predictions are retired, then let the pipe settle
  task automatic drain();
    while (pending_points.size() != 0 || expected_nearest.size() != 0 || in_valid)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    out_stall = 1'b0;
    tri_len = '0;
    tri_v2x = '0;
    tri_v2y = '0;
    failed  = 1'b0;
    no_gaps = 1'b0;
    phase_no = 0;
    cycles  = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset triangle: everything collapses onto the origin
    add_point(0, 0);
    add_point(65536, 65536);
    add_point(-65536, 65536);
    add_random(20);
    drain();

    // ordinary triangle, at least one point per feature plus field extremes
    phase_no = 1;
    set_triangle(10 << 16, 5 << 16, 8 << 16);
    add_point(-65536, -65536);     // V0
    add_point(11 << 16, -65536);   // V1
    add_point(5 << 16, -65536);    // first edge
    add_point(3 << 16, 0);         // on first edge, y zero
    add_point(9 << 16, 5 << 16);   // edge V1-V2
    add_point(65536, 5 << 16);     // edge V0-V2
    add_point(5 << 16, 10 << 16);  // V2
    add_point(5 << 16, 2 << 16);   // face
    add_point(12 << 16, 65536);    // V1 from above
    add_point(-(2 << 16), 65536);  // V0 from above
    add_point(32'sh8000_0000, 32'sh8000_0000);
    add_point(32'sh7fff_ffff, 32'sh7fff_ffff);
    add_point(32'sh8000_0000, 32'sh7fff_ffff);
    add_point(32'sh7fff_ffff, 32'sh8000_0000);
    add_point(-1, -1);
    add_point(1, 1);
    add_point(0, 32'sh7fff_ffff);
    add_random(100);
    drain();

    // extreme registers; no gaps on either side
    phase_no = 2;
    no_gaps = 1'b1;
    set_triangle(32'hffff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    add_point(32'sh7fff_ffff, 32'sh7fff_ffff);
    add_point(32'sh8000_0000, 65536);
    add_random(150);
    drain();
    no_gaps = 1'b0;

    // long receiver hold while the sender keeps offering
    phase_no = 3;
    set_triangle(65536, 0, 65536);
    add_random(150);
    drain();

    // V2 below the first edge
    phase_no = 4;
    set_triangle(8 << 16, 3 << 16, -(6 << 16));
    add_random(100);
    drain();

    // flat triangle: zero divisors
    phase_no = 5;
    set_triangle(6 << 16, 2 << 16, 0);
    add_point(3 << 16, 65536);
    add_random(100);
    drain();

    // random triangles
    for (int k = 0; k < 4; k++) begin
      phase_no = 6 + k;
      set_triangle($urandom >> $urandom_range(0, 16), rand_coord(), rand_coord());
      add_random(80);
      drain();
    end

    if (!failed)
      $display("point_triangle_distance_2d_tb OK");
    else
      $display("point_triangle_distance_2d_tb NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
rtl/ptd_pkg.sv
rtl/ptd_wdiv.sv
rtl/point_triangle_distance_2d.sv
dv/point_triangle_distance_2d_tb.sv
